FILE: hw/rtl/b2da_pkg.sv
`default_nettype none

package b2da_pkg;

  // Input width and decimal capacity
  localparam int VALUE_W  = 64;
  localparam int DIGITS   = 20;
  localparam int BCD_W    = 4 * DIGITS;
  localparam int BIT_CNT_W = 6;
  localparam int DIG_CNT_W = 5;

  // ASCII '0', reduced to the six output bits
  localparam logic [5:0] ASCII_ZERO = 6'd48;

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture a new value, clear the BCD register
    logic step;   // one shift-and-add-3 iteration
    logic shift;  // drop the top BCD digit
    logic emit;   // move the top BCD digit into the output register
  } b2da_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic bit_last;  // final conversion iteration
    logic top_zero;  // top BCD digit is zero
    logic one_left;  // only one digit remains
    logic out_free;  // output register can take a digit this cycle
  } b2da_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/binary_to_decimal_ascii.sv
// Unsigned 64-bit binary to decimal ASCII text.
//
// Item channel: value with item_valid/item_stall; a value transfers at a
// clock edge with item_valid high and item_stall low. Digit channel:
// digit_char/last with digit_valid/digit_stall; one transfer per digit,
// most significant first, no leading zeros, last high on the final digit.
// A zero value gives the single character '0' with last set.
//
// Conversion: after a value transfers, 64 iterations of shift-and-add-3 build
// 20 BCD digits, then leading zeros are dropped one per cycle and the rest
// are unloaded one per cycle while the digit channel does not stall.
//
// A stall on the digit channel holds the current digit and pauses the
// unload; the next value is taken once the final digit sits in the output
// register. Reset clears the controller and the output valid; a
// conversion in progress is lost.
`default_nettype none

module binary_to_decimal_ascii
  import b2da_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_stall,
  input  wire logic [VALUE_W-1:0]  value,
  output logic                     digit_valid,
  input  wire logic                digit_stall,
  output logic [5:0]               digit_char,
  output logic                     last
);

  b2da_cmd_t    cmd;
  b2da_status_t status;

  b2da_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  b2da_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .value       (value),
    .cmd         (cmd),
    .status      (status),
    .digit_valid (digit_valid),
    .digit_stall (digit_stall),
    .digit_char  (digit_char),
    .last        (last)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/b2da_ctrl.sv
`default_nettype none

module b2da_ctrl
  import b2da_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         item_valid,
  output logic              item_stall,
  input  wire b2da_status_t status,
  output b2da_cmd_t         cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_SKIP = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // Take a new value only between conversions
  assign item_stall = (state != S_IDLE);

  // Sequence load, conversion, leading-zero skip and digit unload
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        cmd.step = 1'b1;
        if (status.bit_last) begin
          state_next = S_SKIP;
        end
      end
      S_SKIP: begin
        if (status.top_zero && !status.one_left) begin
          cmd.shift = 1'b1;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          cmd.shift = 1'b1;
          if (status.one_left) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Last digit unloaded returns to idle
  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && status.out_free && status.one_left) |=> (state == S_IDLE))
    else $error("controller did not return to idle after the last digit");

  // An accepted value starts a conversion
  a_load_conv: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> (state == S_CONV))
    else $error("accepted value did not start a conversion");

endmodule

`default_nettype wire

FILE: hw/rtl/b2da_dp.sv
`default_nettype none

module b2da_dp
  import b2da_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [VALUE_W-1:0]  value,
  input  wire b2da_cmd_t           cmd,
  output b2da_status_t             status,
  output logic                     digit_valid,
  input  wire logic                digit_stall,
  output logic [5:0]               digit_char,
  output logic                     last
);

  logic [VALUE_W-1:0]   bin;
  logic [BCD_W-1:0]     bcd;
  logic [BCD_W-1:0]     bcd_adj;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [DIG_CNT_W-1:0] dig_rem;
  logic [3:0]           top_digit;

  assign top_digit = bcd[BCD_W-1 -: 4];

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  assign status.bit_last = (bit_cnt == BIT_CNT_W'(VALUE_W - 1));
  assign status.top_zero = (top_digit == 4'd0);
  assign status.one_left = (dig_rem == '0);
  assign status.out_free = !digit_valid || !digit_stall;

  // Load, then advance the binary and BCD shift registers and the digit count
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin     <= value;
      bcd     <= '0;
      bit_cnt <= '0;
      dig_rem <= DIG_CNT_W'(DIGITS - 1);
    end else if (cmd.step) begin
      bin     <= {bin[VALUE_W-2:0], 1'b0};
      bcd     <= {bcd_adj[BCD_W-2:0], bin[VALUE_W-1]};
      bit_cnt <= bit_cnt + 1'b1;
    end else if (cmd.shift) begin
      bcd     <= {bcd[BCD_W-5:0], 4'd0};
      dig_rem <= dig_rem - 1'b1;
    end
  end

  // Load the output register with the top digit
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      digit_char <= ASCII_ZERO + {2'b00, top_digit};
      last       <= status.one_left;
    end
  end

  // Set on a new digit, drop after its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_valid <= 1'b0;
    end else if (cmd.emit) begin
      digit_valid <= 1'b1;
    end else if (!digit_stall) begin
      digit_valid <= 1'b0;
    end
  end

  // A full 64-bit value never leads with a digit above 1
  a_top_digit: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && status.bit_last) |=> (top_digit <= 4'd1))
    else $error("BCD top digit out of range after conversion");

  // Every digit shown is a decimal character
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    digit_valid |-> (digit_char >= 6'd48 && digit_char <= 6'd57))
    else $error("output character is not a decimal digit");

endmodule

`default_nettype wire
